>>> hdl/cfpalu_pkg.sv
package cfpalu_pkg;

  // Fixed field widths and number format.
  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int TOL_W     = 15;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = 2 * DATA_W + 1;
  localparam int QUO_W     = PROD_W + FRAC_BITS + 1;
  localparam int INT_LIM   = 2 ** (DATA_W - 1 - FRAC_BITS);

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [WIDE_W-1:0] MAG_MAX    = (WIDE_W'(1) << (DATA_W - 1)) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] MAG_MIN    = WIDE_W'(1) << (DATA_W - 1);
  localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MAG  = 3'd5,
    OP_EQ   = 3'd6,
    OP_RSVD = 3'd7
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [DATA_W-1:0] a_real;
    logic signed [DATA_W-1:0] a_imag;
    logic signed [DATA_W-1:0] b_real;
    logic signed [DATA_W-1:0] b_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_real;
    logic signed [DATA_W-1:0] out_imag;
    logic                     saturated;
    logic                     divide_by_zero;
    logic                     is_equal;
  } out_item_t;

  // One queue entry: the item plus what the front end worked out about it.
  typedef struct packed {
    in_item_t item;
    logic     is_div;
    logic     eq;
  } q_entry_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } clip_t;

  // Magnitude of a wide signed value.
  function automatic logic [WIDE_W-1:0] abs_w(input logic signed [WIDE_W-1:0] x);
    return x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
  endfunction

  // Clip a sign and magnitude pair to the signed data range.
  function automatic clip_t clip_sm(input logic neg, input logic [WIDE_W-1:0] mag);
    clip_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > MAG_MAX) begin
        r.sat = 1'b1;
        r.val = S_MAX;
      end else begin
        r.val = mag[DATA_W-1:0];
      end
    end else begin
      if (mag > MAG_MIN) begin
        r.sat = 1'b1;
        r.val = S_MIN;
      end else begin
        r.val = DATA_W'(0) - mag[DATA_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic clip_t clip_s(input logic signed [WIDE_W-1:0] x);
    return clip_sm(x[WIDE_W-1], abs_w(x));
  endfunction

  // Round a product sum half away from zero to FRAC_BITS, then clip.
  function automatic clip_t scale_sum(input logic signed [WIDE_W-1:0] x);
    logic [WIDE_W-1:0] m;
    m = (abs_w(x) + ROUND_HALF) >> FRAC_BITS;
    return clip_sm(x[WIDE_W-1], m);
  endfunction

endpackage

>>> hdl/cfpalu_front.sv
module cfpalu_front
  import cfpalu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_item_t         in_data,
  input  logic             cfg_valid,
  input  logic [TOL_W-1:0] cfg_data,
  input  logic             q_full,
  output logic             push,
  output q_entry_t         push_data
);

  logic [TOL_W-1:0]         tol_r;
  logic signed [DATA_W:0]   d_re;
  logic signed [DATA_W:0]   d_im;
  logic                     near;

  // Tolerance register; the port always takes a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // Part differences against the tolerance for the equality opcode.
  always_comb begin
    d_re = (DATA_W+1)'(in_data.a_real) - (DATA_W+1)'(in_data.b_real);
    d_im = (DATA_W+1)'(in_data.a_imag) - (DATA_W+1)'(in_data.b_imag);
    near = (abs_w(WIDE_W'(d_re)) < WIDE_W'(tol_r)) &&
           (abs_w(WIDE_W'(d_im)) < WIDE_W'(tol_r));
  end

  // Classify the item and hand it to the queue.
  always_comb begin
    push             = start && !q_full;
    push_data.item   = in_data;
    push_data.is_div = (in_data.opcode == OP_DIV);
    push_data.eq     = (in_data.opcode == OP_EQ) && near;
  end

endmodule

>>> hdl/cfpalu_queue.sv
module cfpalu_queue
  import cfpalu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     head_vld,
  output q_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Pointer and fill count updates.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rd_r];

endmodule

>>> hdl/cfpalu_back.sv
module cfpalu_back
  import cfpalu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_vld,
  input  q_entry_t  head,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  // Product stage.
  logic                     s1_vld_r;
  q_entry_t                 s1_ent_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_brbr_r, p_bibi_r;
  logic signed [DATA_W-1:0] bx, by;

  // Divider.
  logic                     div_act_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [PROD_W-1:0]        den_r;
  logic [QUO_W-1:0]         dq_r   [2];
  logic [QUO_W-1:0]         dq_nxt [2];
  logic [PROD_W-1:0]        rem_r  [2];
  logic [PROD_W-1:0]        rem_nxt[2];
  logic                     neg_r  [2];
  logic [PROD_W:0]          trial  [2];
  logic                     ge     [2];
  logic [PROD_W-1:0]        den_c;
  logic signed [WIDE_W-1:0] num_c  [2];
  logic [WIDE_W-1:0]        num_mag[2];
  logic                     dz;
  logic                     div_load;
  logic                     div_fin;

  // Result assembly.
  logic                     out_vld_r;
  out_item_t                out_r, out_nxt;
  clip_t                    c_re, c_im;
  logic signed [WIDE_W-1:0] ar_w, ai_w, br_w, bi_w;
  logic [QUO_W-1:0]         rnd    [2];
  clip_t                    dclip  [2];

  // The magnitude opcode squares a by feeding a in place of b.
  always_comb begin
    bx = (head.item.opcode == OP_MAG) ? head.item.a_real : head.item.b_real;
    by = (head.item.opcode == OP_MAG) ? head.item.a_imag : head.item.b_imag;
  end

  // Denominator and numerators of a division waiting in the product stage.
  always_comb begin
    den_c      = PROD_W'(unsigned'(p_brbr_r)) + PROD_W'(unsigned'(p_bibi_r));
    num_c[0]   = WIDE_W'(p_rr_r) + WIDE_W'(p_ii_r);
    num_c[1]   = WIDE_W'(p_ir_r) - WIDE_W'(p_ri_r);
    num_mag[0] = abs_w(num_c[0]);
    num_mag[1] = abs_w(num_c[1]);
    dz         = (den_c == '0);
    div_load   = s1_vld_r && s1_ent_r.is_div && !dz;
    div_fin    = div_act_r && (cnt_r == CNT_W'(QUO_W));
    pop        = head_vld && !div_act_r && !div_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_ent_r <= '0;
    end else begin
      s1_vld_r <= pop;
      if (pop) begin
        s1_ent_r <= head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_rr_r   <= head.item.a_real * bx;
      p_ii_r   <= head.item.a_imag * by;
      p_ri_r   <= head.item.a_real * head.item.b_imag;
      p_ir_r   <= head.item.a_imag * head.item.b_real;
      p_brbr_r <= head.item.b_real * head.item.b_real;
      p_bibi_r <= head.item.b_imag * head.item.b_imag;
    end
  end

  // One restoring division step per cycle on both lanes.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      trial[k]   = {rem_r[k], dq_r[k][QUO_W-1]};
      ge[k]      = (trial[k] >= {1'b0, den_r});
      rem_nxt[k] = ge[k] ? PROD_W'(trial[k] - {1'b0, den_r}) : trial[k][PROD_W-1:0];
      dq_nxt[k]  = {dq_r[k][QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_act_r <= 1'b0;
    end else if (div_load) begin
      div_act_r <= 1'b1;
    end else if (div_fin) begin
      div_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      cnt_r <= '0;
      den_r <= den_c;
      for (int k = 0; k < 2; k++) begin
        dq_r[k]  <= {num_mag[k][PROD_W-1:0], {(FRAC_BITS+1){1'b0}}};
        rem_r[k] <= '0;
        neg_r[k] <= num_c[k][WIDE_W-1];
      end
    end else if (div_act_r && !div_fin) begin
      cnt_r <= cnt_r + CNT_W'(1);
      for (int k = 0; k < 2; k++) begin
        dq_r[k]  <= dq_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
    end
  end

  // Quotient rounding, with an integer part over range forced to clip.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rnd[k] = (dq_r[k] + QUO_W'(1)) >> 1;
      if (dq_r[k][QUO_W-1:FRAC_BITS+1] > PROD_W'(INT_LIM)) begin
        dclip[k] = clip_sm(neg_r[k], MAG_MIN + WIDE_W'(1));
      end else begin
        dclip[k] = clip_sm(neg_r[k], rnd[k][WIDE_W-1:0]);
      end
    end
  end

  // Result of the item in the product stage, or of a finished division.
  always_comb begin
    ar_w = WIDE_W'(s1_ent_r.item.a_real);
    ai_w = WIDE_W'(s1_ent_r.item.a_imag);
    br_w = WIDE_W'(s1_ent_r.item.b_real);
    bi_w = WIDE_W'(s1_ent_r.item.b_imag);
    c_re = '0;
    c_im = '0;
    out_nxt = '0;
    unique case (s1_ent_r.item.opcode)
      OP_ADD: begin
        c_re = clip_s(ar_w + br_w);
        c_im = clip_s(ai_w + bi_w);
      end
      OP_SUB: begin
        c_re = clip_s(ar_w - br_w);
        c_im = clip_s(ai_w - bi_w);
      end
      OP_MUL: begin
        c_re = scale_sum(WIDE_W'(p_rr_r) - WIDE_W'(p_ii_r));
        c_im = scale_sum(WIDE_W'(p_ri_r) + WIDE_W'(p_ir_r));
      end
      OP_DIV: begin
        out_nxt.divide_by_zero = 1'b1;
      end
      OP_CONJ: begin
        c_re.val = s1_ent_r.item.a_real;
        c_im     = clip_s(-ai_w);
      end
      OP_MAG: begin
        c_re = scale_sum(WIDE_W'(p_rr_r) + WIDE_W'(p_ii_r));
      end
      OP_EQ: begin
        out_nxt.is_equal = s1_ent_r.eq;
      end
      OP_RSVD: begin
        c_re = '0;
      end
    endcase
    if (div_fin) begin
      c_re = dclip[0];
      c_im = dclip[1];
      out_nxt.divide_by_zero = 1'b0;
      out_nxt.is_equal       = 1'b0;
    end
    out_nxt.out_real  = c_re.val;
    out_nxt.out_imag  = c_im.val;
    out_nxt.saturated = c_re.sat | c_im.sat;
  end

  // Output register; every result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= (s1_vld_r && !div_load) || div_fin;
    end
  end

  always_ff @(posedge clk) begin
    if ((s1_vld_r && !div_load) || div_fin) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

>>> hdl/complex_fixed_point_alu_core.sv
// Complex arithmetic unit on signed Q4.12 operands.
// Input: an item (opcode, a, b) is taken at a clock edge where start is high
// and busy is low. busy rises only when the input queue is full.
// Output: each result appears on out_data for exactly one cycle with
// out_valid high; the receiver cannot hold it off, so nothing stalls there.
// Configuration: cfg_data writes the equality tolerance whenever cfg_valid
// is high; cfg_ready is always high.
// Add, sub, mul, conjugate, magnitude and equality pass the queue entry,
// the product stage and the output register; while no division holds the
// back end, one item per cycle is sustained. Division runs on a restoring
// divider that makes one quotient bit per cycle over 45 bits, and the back
// end takes no new item while it runs; items queue in front of it in order.
// Reset (synchronous, active low) empties the queue and the pipeline and
// sets the tolerance to one LSB (exact equality). No clearing pass is needed.
module complex_fixed_point_alu_core
  import cfpalu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data
);

  logic     q_full;
  logic     push;
  q_entry_t push_data;
  logic     pop;
  logic     head_vld;
  q_entry_t head;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  cfpalu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  cfpalu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .head_vld  (head_vld),
    .head      (head)
  );

  cfpalu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (head_vld),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hdl/cfpalu_checker.sv
module cfpalu_checker
  import cfpalu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // Reset leaves no result in flight and the queue empty.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result or busy after reset");

  // A zero denominator gives a clean zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |->
      out_data.out_real == '0 && out_data.out_imag == '0 && !out_data.saturated &&
      !out_data.is_equal)
    else $error("divide by zero result not zero");

  // The equality test reports no value and no saturation.
  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_equal |->
      out_data.out_real == '0 && out_data.out_imag == '0 && !out_data.saturated)
    else $error("equality result carries data");

  // A saturated result holds a range limit in at least one part.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.out_real == S_MAX || out_data.out_real == S_MIN ||
      out_data.out_imag == S_MAX || out_data.out_imag == S_MIN)
    else $error("saturated result not at a limit");

endmodule

bind complex_fixed_point_alu_core cfpalu_checker u_cfpalu_checker (.*);

>>> verif/testbench.sv
module testbench;
  import cfpalu_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_data;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data;

  // Tolerance as the block holds it, and the results still to come.
  logic [TOL_W-1:0] tol_now;
  out_item_t        pending_results[$];
  // A directed row may carry its own result, used in place of the computed one.
  logic             pin_valid;
  out_item_t        pin_result;
  int               errors;

  // Stimulus row for the directed part.
  typedef struct {
    opcode_t   op;
    int        ar;
    int        ai;
    int        br;
    int        bi;
    bit        has_exp;
    out_item_t exp_res;
  } vector_t;

  complex_fixed_point_alu_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

  // Clip a sign and magnitude to the signed 16-bit range.
  function automatic logic signed [DATA_W-1:0] clip_to(input bit neg,
      input longint unsigned mag, inout bit sat);
    if (!neg) begin
      if (mag > 32767) begin
        sat = 1'b1;
        return S_MAX;
      end
      return DATA_W'(mag);
    end
    if (mag > 32768) begin
      sat = 1'b1;
      return S_MIN;
    end
    return DATA_W'(-longint'(mag));
  endfunction

  // Sum of two products as sign and magnitude; zero is positive.
  function automatic void add_sm(input longint p, input longint q,
      output bit neg, output longint unsigned mag);
    longint s;
    s = p + q;
    neg = s < 0;
    mag = neg ? longint'(-s) : s;
  endfunction

  // Round a product sum half away from zero to the fraction width.
  function automatic logic signed [DATA_W-1:0] round_prod(input longint p,
      input longint q, inout bit sat);
    bit neg;
    longint unsigned mag;
    add_sm(p, q, neg, mag);
    mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clip_to(neg, mag, sat);
  endfunction

  // Exact quotient (p + q) * 2^FRAC_BITS / den, rounded half away from zero.
  function automatic logic signed [DATA_W-1:0] quotient(input longint p,
      input longint q, input longint unsigned den, inout bit sat);
    bit neg;
    longint unsigned num, ip, rem, res;
    add_sm(p, q, neg, num);
    ip  = num / den;
    rem = num % den;
    if (ip > INT_LIM) return clip_to(neg, 32769, sat);
    res = ip;
    for (int i = 0; i <= FRAC_BITS; i++) begin
      rem = rem << 1;
      res = res << 1;
      if (rem >= den) begin
        rem = rem - den;
        res = res | 1;
      end
    end
    res = (res + 1) >> 1;
    return clip_to(neg, res, sat);
  endfunction

  // Expected result of one operation under the given tolerance.
  function automatic out_item_t alu_result(input in_item_t it, input logic [TOL_W-1:0] tol);
    out_item_t r;
    longint ar, ai, br, bi, dr, di;
    longint unsigned den;
    bit sat;
    ar = it.a_real;
    ai = it.a_imag;
    br = it.b_real;
    bi = it.b_imag;
    sat = 1'b0;
    r = '0;
    case (it.opcode)
      OP_ADD: begin
        r.out_real = clip_to(ar + br < 0, (ar + br < 0) ? -(ar + br) : ar + br, sat);
        r.out_imag = clip_to(ai + bi < 0, (ai + bi < 0) ? -(ai + bi) : ai + bi, sat);
      end
      OP_SUB: begin
        r.out_real = clip_to(ar - br < 0, (ar - br < 0) ? -(ar - br) : ar - br, sat);
        r.out_imag = clip_to(ai - bi < 0, (ai - bi < 0) ? -(ai - bi) : ai - bi, sat);
      end
      OP_MUL: begin
        r.out_real = round_prod(ar * br, -(ai * bi), sat);
        r.out_imag = round_prod(ar * bi, ai * br, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          r.out_real = quotient(ar * br, ai * bi, den, sat);
          r.out_imag = quotient(ai * br, -(ar * bi), den, sat);
        end
      end
      OP_CONJ: begin
        r.out_real = it.a_real;
        r.out_imag = clip_to(ai > 0, (ai > 0) ? ai : -ai, sat);
      end
      OP_MAG: begin
        r.out_real = round_prod(ar * ar, ai * ai, sat);
      end
      OP_EQ: begin
        dr = (ar > br) ? ar - br : br - ar;
        di = (ai > bi) ? ai - bi : bi - ai;
        r.is_equal = (dr < tol) && (di < tol);
      end
      default: ;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  // Accepted items at the rising edge, and checking of each result.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.out_real !== want.out_real) begin
            $error("out_real: expected %0d, actual %0d", want.out_real, out_data.out_real);
            errors++;
          end
          if (out_data.out_imag !== want.out_imag) begin
            $error("out_imag: expected %0d, actual %0d", want.out_imag, out_data.out_imag);
            errors++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, out_data.saturated);
            errors++;
          end
          if (out_data.divide_by_zero !== want.divide_by_zero) begin
            $error("divide_by_zero: expected %0b, actual %0b", want.divide_by_zero,
                   out_data.divide_by_zero);
            errors++;
          end
          if (out_data.is_equal !== want.is_equal) begin
            $error("is_equal: expected %0b, actual %0b", want.is_equal, out_data.is_equal);
            errors++;
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(pin_valid ? pin_result : alu_result(in_data, tol_now));
    end
  end

  // Hold start low for a gap, then present one item until its transfer.
  task automatic send_op(input in_item_t it, input int gap, input bit pinned,
      input out_item_t pinned_res);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_data    <= it;
    pin_valid  <= pinned;
    pin_result <= pinned_res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Tolerance writes happen only with the block drained.
  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tol_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Operand part: full-range values, values within +/-8192, extremes, zero and small values mixed.
  function automatic logic signed [DATA_W-1:0] pick_part();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return DATA_W'($urandom_range(0, 16) - 8);
      4, 5:    return DATA_W'($urandom_range(0, 16384) - 8192);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // One random item; equality and division get targeted operands at times.
  function automatic in_item_t pick_item(input logic [TOL_W-1:0] tol);
    in_item_t it;
    int span;
    it.opcode = opcode_t'($urandom_range(0, 7));
    it.a_real = pick_part();
    it.a_imag = pick_part();
    it.b_real = pick_part();
    it.b_imag = pick_part();
    span = (tol > 64) ? 64 : tol + 2;
    if (it.opcode == OP_EQ && $urandom_range(0, 2) != 0) begin
      it.b_real = it.a_real + DATA_W'($urandom_range(0, 2 * span) - span);
      it.b_imag = it.a_imag + DATA_W'($urandom_range(0, 2 * span) - span);
    end
    if (it.opcode == OP_DIV && $urandom_range(0, 9) == 0) begin
      it.b_real = '0;
      it.b_imag = '0;
    end
    return it;
  endfunction

  function automatic in_item_t mk(input opcode_t op, input int ar, input int ai,
      input int br, input int bi);
    in_item_t it;
    it.opcode = op;
    it.a_real = DATA_W'(ar);
    it.a_imag = DATA_W'(ai);
    it.b_real = DATA_W'(br);
    it.b_imag = DATA_W'(bi);
    return it;
  endfunction

  function automatic out_item_t res(input int re, input int im, input bit sat,
      input bit dz, input bit eq);
    out_item_t r;
    r.out_real       = DATA_W'(re);
    r.out_imag       = DATA_W'(im);
    r.saturated      = sat;
    r.divide_by_zero = dz;
    r.is_equal       = eq;
    return r;
  endfunction

  initial begin
    vector_t          directed[$];
    vector_t          v;
    in_item_t         it;
    logic [TOL_W-1:0] tol_plan[6];
    int               burst;
    int               gap;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    pin_valid  = 1'b0;
    pin_result = '0;
    tol_now    = 1;
    errors     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: extremes, each operation and the special cases.
    directed = '{
      '{OP_ADD,  32767,  32767,  32767, -32768, 1, res(32767, -1, 1, 0, 0)},
      '{OP_ADD, -32768, -32768, -32768, -32768, 1, res(-32768, -32768, 1, 0, 0)},
      '{OP_SUB,  32767, -32768, -32768,  32767, 1, res(32767, -32768, 1, 0, 0)},
      '{OP_SUB,   1234,   -55,     34,     45, 1, res(1200, -100, 0, 0, 0)},
      '{OP_MUL,   4096,      0,   4096,      0, 1, res(4096, 0, 0, 0, 0)},
      '{OP_MUL, -32768, -32768, -32768, -32768, 0, res(0, 0, 0, 0, 0)},
      '{OP_MUL,  32767,  32767, -32768,  32767, 0, res(0, 0, 0, 0, 0)},
      '{OP_MUL,      1,      1,   2048,   2048, 0, res(0, 0, 0, 0, 0)},
      '{OP_DIV,   1234,   -777,      0,      0, 1, res(0, 0, 0, 1, 0)},
      '{OP_DIV,   4096,   4096,   4096,      0, 1, res(4096, 4096, 0, 0, 0)},
      '{OP_DIV,  32767, -32768,      1,      0, 0, res(0, 0, 0, 0, 0)},
      '{OP_DIV,      1,      0,      3,      0, 0, res(0, 0, 0, 0, 0)},
      '{OP_DIV, -32768,  32767, -32768, -32768, 0, res(0, 0, 0, 0, 0)},
      '{OP_CONJ,   100, -32768,      5,      5, 1, res(100, 32767, 1, 0, 0)},
      '{OP_CONJ,-32768,  32767,      0,      0, 1, res(-32768, -32767, 0, 0, 0)},
      '{OP_MAG, -32768, -32768,      0,      0, 1, res(32767, 0, 1, 0, 0)},
      '{OP_MAG,   4096,   4096,    999,    999, 1, res(8192, 0, 0, 0, 0)},
      '{OP_MAG,     45,    -45,      0,      0, 0, res(0, 0, 0, 0, 0)},
      '{OP_EQ,     300,   -300,    300,   -300, 1, res(0, 0, 0, 0, 1)},
      '{OP_EQ,     300,   -300,    301,   -300, 1, res(0, 0, 0, 0, 0)},
      '{OP_EQ,       0,      0,      0,      0, 1, res(0, 0, 0, 0, 1)},
      '{OP_EQ,   32767, -32768, -32768,  32767, 1, res(0, 0, 0, 0, 0)},
      '{OP_RSVD, 32767, -32768,  32767, -32768, 1, res(0, 0, 0, 0, 0)}
    };
    foreach (directed[i]) begin
      v = directed[i];
      send_op(mk(v.op, v.ar, v.ai, v.br, v.bi), 0, v.has_exp, v.exp_res);
    end

    // Random phases, each under its own tolerance, extremes included.
    tol_plan = '{15'd1, 15'd0, 15'd32767, 15'd16, 15'd4096, 15'd1};
    tol_plan[4] = TOL_W'($urandom);
    foreach (tol_plan[p]) begin
      write_tolerance(tol_plan[p]);
      burst = 0;
      for (int n = 0; n < 292; n++) begin
        gap = 0;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst--;
        it = pick_item(tol_now);
        send_op(it, gap, 1'b0, '0);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain the block, then allow for the slowest operation.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
